// ===== src/mpid_pkg.sv =====
// Shared types and constants for the multichannel PID core.
// Used by mpid_csr and multichannel_pid_antiwindup_core; no dependencies.
package mpid_pkg;

   // Defaults for the top-level parameters
   localparam int CHANNELS_DEF       = 8;
   localparam int GAIN_FRAC_BITS_DEF = 12;

   // Field and datapath widths
   localparam int CHAN_W     = 3;
   localparam int POS_W      = 24;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 23;
   localparam int DRIVE_W    = 8;
   localparam int ERR_W      = 25;
   localparam int INTEG_W    = 24;
   localparam int SUM_W      = 26;
   localparam int DER_W      = 26;
   localparam int PROD_P_W   = ERR_W + GAIN_W;
   localparam int PROD_I_W   = INTEG_W + GAIN_W;
   localparam int PROD_D_W   = DER_W + GAIN_W;
   localparam int ACC_W      = 44;
   localparam int DRIVE_MAG_W = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Input transfer payload
   typedef struct packed {
      logic [CHAN_W-1:0]        channel;
      logic signed [POS_W-1:0]  setpoint;
      logic signed [POS_W-1:0]  measurement;
   } req_type;

   // Result transfer payload
   typedef struct packed {
      logic [CHAN_W-1:0]         channel_out;
      logic signed [DRIVE_W-1:0] drive;
   } rsp_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       integral_limit;
   } gains_type;

   // Register map, word index
   typedef enum logic [1:0] {
      REG_PROP_GAIN      = 2'd0,
      REG_INTEG_GAIN     = 2'd1,
      REG_DERIV_GAIN     = 2'd2,
      REG_INTEGRAL_LIMIT = 2'd3
   } reg_index_type;

endpackage

// ===== src/mpid_csr.sv =====
// APB-style register file holding the PID gains and the integral limit.
// Depends on mpid_pkg.
module mpid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mpid_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mpid_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mpid_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output mpid_pkg::gains_type                gains
);

   mpid_pkg::gains_type     gains_ff;
   mpid_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign reg_idx    = mpid_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign gains      = gains_ff;

   // Register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            mpid_pkg::REG_PROP_GAIN: begin
               gains_ff.prop_gain <= csr_pwdata[mpid_pkg::GAIN_W-1:0];
            end
            mpid_pkg::REG_INTEG_GAIN: begin
               gains_ff.integ_gain <= csr_pwdata[mpid_pkg::GAIN_W-1:0];
            end
            mpid_pkg::REG_DERIV_GAIN: begin
               gains_ff.deriv_gain <= csr_pwdata[mpid_pkg::GAIN_W-1:0];
            end
            mpid_pkg::REG_INTEGRAL_LIMIT: begin
               gains_ff.integral_limit <= csr_pwdata[mpid_pkg::LIMIT_W-1:0];
            end
         endcase
      end
   end

   // Read mux, fields returned zero-extended
   always_comb begin
      unique case (reg_idx)
         mpid_pkg::REG_PROP_GAIN: begin
            csr_prdata = mpid_pkg::CSR_DATA_W'(unsigned'(gains_ff.prop_gain));
         end
         mpid_pkg::REG_INTEG_GAIN: begin
            csr_prdata = mpid_pkg::CSR_DATA_W'(unsigned'(gains_ff.integ_gain));
         end
         mpid_pkg::REG_DERIV_GAIN: begin
            csr_prdata = mpid_pkg::CSR_DATA_W'(unsigned'(gains_ff.deriv_gain));
         end
         mpid_pkg::REG_INTEGRAL_LIMIT: begin
            csr_prdata = mpid_pkg::CSR_DATA_W'(gains_ff.integral_limit);
         end
      endcase
   end

endmodule

// ===== src/multichannel_pid_antiwindup_core.sv =====
// Multichannel PID core with integral clamp; top level.
// Depends on mpid_pkg and mpid_csr.
// The result passes through the input register, the product register and the
// result register. Throughput: one item per cycle while rsp_stall does not
// hold the result register; the per-channel integral and last error of an
// in-range channel are updated as an item leaves the input register, so the
// next item on the same channel sees them at once.
// Reset (synchronous): pipeline emptied, gains and limit zero, all channel
// state zero.
module multichannel_pid_antiwindup_core #(
   parameter int CHANNELS       = mpid_pkg::CHANNELS_DEF,
   parameter int GAIN_FRAC_BITS = mpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mpid_pkg::req_type               req_payload,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mpid_pkg::rsp_type               rsp_payload,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mpid_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mpid_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mpid_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_EXT_W = CH_IDX_W + mpid_pkg::CHAN_W;

   mpid_pkg::gains_type gains;

   mpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage moves when the next one is free
   // ---------------------------------------------------------------
   logic s_vld_ff, p_vld_ff, out_vld_ff;
   logic out_free, p_free, s_free;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign p_free    = !p_vld_ff || out_free;
   assign s_free    = !s_vld_ff || p_free;
   assign req_stall = !s_free;

   // Input register
   mpid_pkg::req_type s_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (s_free) begin
         s_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s_free && req_valid) begin
         s_req_ff <= req_payload;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: error, clamped integral, derivative, channel state
   // ---------------------------------------------------------------
   logic signed [mpid_pkg::INTEG_W-1:0] integral_ff [CHANNELS];
   logic signed [mpid_pkg::ERR_W-1:0]   last_err_ff [CHANNELS];

   logic [CH_EXT_W-1:0]                 ch_ext;
   logic [CH_IDX_W-1:0]                 ch_idx;
   logic                                ch_ok;
   logic                                upd_en;
   logic signed [mpid_pkg::INTEG_W-1:0] integ_rd;
   logic signed [mpid_pkg::ERR_W-1:0]   last_err_rd;
   logic signed [mpid_pkg::ERR_W-1:0]   err;
   logic signed [mpid_pkg::SUM_W-1:0]   sum;
   logic signed [mpid_pkg::SUM_W-1:0]   lim_s;
   logic signed [mpid_pkg::SUM_W-1:0]   integ_w;
   logic signed [mpid_pkg::INTEG_W-1:0] integ_in;
   logic signed [mpid_pkg::DER_W-1:0]   der;

   assign ch_ext = CH_EXT_W'(s_req_ff.channel);
   assign ch_idx = ch_ext[CH_IDX_W-1:0];
   assign ch_ok  = (ch_ext < CH_EXT_W'(CHANNELS));
   assign upd_en = s_vld_ff && p_free && ch_ok;

   assign integ_rd    = integral_ff[ch_idx];
   assign last_err_rd = last_err_ff[ch_idx];

   assign err = mpid_pkg::ERR_W'(s_req_ff.setpoint)
              - mpid_pkg::ERR_W'(s_req_ff.measurement);
   assign sum = mpid_pkg::SUM_W'(integ_rd) + mpid_pkg::SUM_W'(err);
   assign lim_s = mpid_pkg::SUM_W'(signed'({1'b0, gains.integral_limit}));
   assign der = mpid_pkg::DER_W'(err) - mpid_pkg::DER_W'(last_err_rd);

   // Clamp: a magnitude at or above the limit pins to +/- limit
   always_comb begin
      if (!sum[mpid_pkg::SUM_W-1]) begin
         integ_w = (sum < lim_s) ? sum : lim_s;
      end else begin
         integ_w = (sum > -lim_s) ? sum : -lim_s;
      end
   end

   assign integ_in = integ_w[mpid_pkg::INTEG_W-1:0];

   // Channel state update as the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            integral_ff[k] <= '0;
            last_err_ff[k] <= '0;
         end
      end else if (upd_en) begin
         integral_ff[ch_idx] <= integ_in;
         last_err_ff[ch_idx] <= err;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: gain products
   // ---------------------------------------------------------------
   logic signed [mpid_pkg::PROD_P_W-1:0] prod_p_in, prod_p_ff;
   logic signed [mpid_pkg::PROD_I_W-1:0] prod_i_in, prod_i_ff;
   logic signed [mpid_pkg::PROD_D_W-1:0] prod_d_in, prod_d_ff;
   logic [mpid_pkg::CHAN_W-1:0]          p_ch_ff;
   logic                                 p_ok_ff;

   assign prod_p_in = err * gains.prop_gain;
   assign prod_i_in = integ_in * gains.integ_gain;
   assign prod_d_in = der * gains.deriv_gain;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (p_free) begin
         p_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_free && s_vld_ff) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
         p_ch_ff   <= s_req_ff.channel;
         p_ok_ff   <= ch_ok;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: sum, truncate toward zero, saturate to +/-127
   // ---------------------------------------------------------------
   logic signed [mpid_pkg::ACC_W-1:0]     acc;
   logic                                  acc_neg;
   logic [mpid_pkg::ACC_W-1:0]            acc_mag;
   logic [mpid_pkg::ACC_W-1:0]            acc_shr;
   logic [mpid_pkg::DRIVE_MAG_W-1:0]      drive_mag;
   logic signed [mpid_pkg::DRIVE_W-1:0]   drive_in;
   mpid_pkg::rsp_type                     out_ff;

   assign acc = mpid_pkg::ACC_W'(prod_p_ff) + mpid_pkg::ACC_W'(prod_i_ff)
              + mpid_pkg::ACC_W'(prod_d_ff);
   assign acc_neg = acc[mpid_pkg::ACC_W-1];
   assign acc_mag = acc_neg ? unsigned'(-acc) : unsigned'(acc);
   assign acc_shr = acc_mag >> GAIN_FRAC_BITS;
   assign drive_mag = (|acc_shr[mpid_pkg::ACC_W-1:mpid_pkg::DRIVE_MAG_W])
                    ? '1 : acc_shr[mpid_pkg::DRIVE_MAG_W-1:0];

   always_comb begin
      if (!p_ok_ff) begin
         drive_in = '0;
      end else if (acc_neg) begin
         drive_in = -signed'({1'b0, drive_mag});
      end else begin
         drive_in = signed'({1'b0, drive_mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && p_vld_ff) begin
         out_ff.channel_out <= p_ch_ff;
         out_ff.drive       <= drive_in;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Saturation never yields the asymmetric code
   a_drive_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.drive != -8'sd128))
      else $error("drive left the +/-127 range");

   // An integral written to the store respects the current limit
   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      upd_en |-> ((integ_w <= lim_s) && (integ_w >= -lim_s)))
      else $error("integral written outside the limit");

   // An empty result register never backs up the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff |-> !req_stall)
      else $error("input stalled with an empty pipeline tail");

   // Updated channel state is visible to the following item
   a_state_written: assert property (@(posedge clock) disable iff (reset)
      upd_en |=> (integral_ff[$past(ch_idx)] == $past(integ_in)))
      else $error("integral store not updated");

endmodule
